### rtl/dm96_pkg.sv
// Shared constants, types and status codes for the decimal96 multiplier.
package dm96_pkg;

    localparam int DEF_MANT_BITS = 96;
    localparam int SCALE_BITS    = 5;
    localparam int PSCALE_BITS   = 6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LARGE = 2'd1,
        ST_SMALL = 2'd2
    } status_t;

    // Control from the sequencer to a serial unit.
    typedef struct packed {
        logic load;
        logic start;
    } unit_ctrl_t;

endpackage

### rtl/dm96_div10.sv
// Bit-serial divide by ten, one quotient bit per cycle, MSB first.
module dm96_div10
    import dm96_pkg::*;
#(
    parameter int MANT_BITS = DEF_MANT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  unit_ctrl_t           ctrl,
    input  logic [MANT_BITS-1:0] load_val,
    output logic [MANT_BITS-1:0] value,
    output logic                 done
);

    localparam int CNT_BITS = $clog2(MANT_BITS + 1);

    logic [MANT_BITS-1:0] val_reg, val_next;
    logic [3:0]           rem_reg, rem_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [4:0]           trial;
    logic                 qbit;

    // Shift the dividend out at the top and the quotient bit in at the bottom.
    always_comb begin
        trial     = {rem_reg, val_reg[MANT_BITS-1]};
        qbit      = (trial >= 5'd10);
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.load) begin
            val_next = load_val;
        end else if (ctrl.start) begin
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? 4'(trial - 5'd10) : trial[3:0];
            val_next = {val_reg[MANT_BITS-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(MANT_BITS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
        end
        val_reg <= val_next;
    end

    assign value = val_reg;
    assign done  = !busy_reg && !ctrl.start;

endmodule

### rtl/dm96_mult.sv
// Shift-and-add multiplier: one multiplier bit per cycle, product held in a 2N register.
module dm96_mult
    import dm96_pkg::*;
#(
    parameter int MANT_BITS = DEF_MANT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  unit_ctrl_t           ctrl,
    input  logic [MANT_BITS-1:0] opa,
    input  logic [MANT_BITS-1:0] opb,
    output logic [MANT_BITS-1:0] prod,
    output logic                 over,
    output logic                 done
);

    localparam int CNT_BITS = $clog2(MANT_BITS + 1);

    logic [2*MANT_BITS-1:0] acc_reg, acc_next;
    logic [MANT_BITS-1:0]   mcand_reg, mcand_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic [MANT_BITS:0]     sum;

    // Low half of acc holds the multiplier bits; shift right each cycle while busy.
    always_comb begin
        sum        = {1'b0, acc_reg[2*MANT_BITS-1:MANT_BITS]}
                   + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (ctrl.start) begin
            acc_next   = {{MANT_BITS{1'b0}}, opb};
            mcand_next = opa;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            acc_next = {sum, acc_reg[MANT_BITS-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(MANT_BITS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign prod = acc_reg[MANT_BITS-1:0];
    assign over = |acc_reg[2*MANT_BITS-1:MANT_BITS];
    assign done = !busy_reg && !ctrl.start && !ctrl.load;

endmodule

### rtl/decimal96_multiply.sv
// Top level of the decimal96 multiplier: sequencer and stream ports.
//
//  port group | dir | fields (tdata low bit up)
//  s_*        | in  | a_mant_low, a_mant_high, a_scale, a_negative,
//             |     | b_mant_low, b_mant_high, b_scale, b_negative
//  m_*        | out | prod_mant_low, prod_mant_high, prod_scale, prod_negative, status
//
// Each word is multiplied; while the product overflows and the summed scale is not
// used up, a and b in turn are divided by ten and the multiply retried, using the
// bit-serial multiplier and divider.
// One word is worked at a time. A finished result is held in the output register
// until taken; the next finished result waits while it is still held, and a new word
// is accepted once the previous one has moved there. Reset clears state and valid.
module decimal96_multiply
    import dm96_pkg::*;
#(
    parameter int MANT_BITS = DEF_MANT_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_mant_low[63:0], a_mant_high[95:64], a_scale[100:96], a_negative[101],
    // b_mant_low[165:102], b_mant_high[197:166], b_scale[202:198], b_negative[203]
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // prod_mant_low[63:0], prod_mant_high[95:64], prod_scale[101:96],
    // prod_negative[102], status[104:103]
    output logic [111:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_OUT
    } state_t;

    state_t               state_reg;
    logic [PSCALE_BITS-1:0] total_reg, count_reg;
    logic                 neg_reg, sel_b_reg;
    logic [MANT_BITS-1:0] a_reg, b_reg;
    logic [111:0]         out_reg;
    logic                 out_valid_reg;
    logic                 div_start_reg;
    unit_ctrl_t           mul_ctrl, div_ctrl;
    logic [MANT_BITS-1:0] prod, div_val;
    logic                 over, mul_done, div_done;
    logic [95:0]          prod96;
    logic [MANT_BITS+95:0] ina, inb;

    assign ina = {{MANT_BITS{1'b0}}, s_tdata[95:0]};
    assign inb = {{MANT_BITS{1'b0}}, s_tdata[197:102]};

    dm96_mult #(.MANT_BITS(MANT_BITS)) u_mult (
        .aclk(aclk), .aresetn(aresetn), .ctrl(mul_ctrl),
        .opa(a_reg), .opb(b_reg), .prod(prod), .over(over), .done(mul_done)
    );

    dm96_div10 #(.MANT_BITS(MANT_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctrl(div_ctrl),
        .load_val(sel_b_reg ? b_reg : a_reg), .value(div_val), .done(div_done)
    );

    // Divider start goes out in the cycle after load.
    always_comb begin
        mul_ctrl       = '0;
        div_ctrl       = '0;
        mul_ctrl.start = (state_reg == S_MUL_GO);
        div_ctrl.load  = (state_reg == S_DIV_GO);
        div_ctrl.start = div_start_reg;
    end

    // Product bits 0..95 only; narrower mantissas are zero extended.
    assign prod96 = 96'({{96{1'b0}}, prod});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= (state_reg == S_DIV_GO);
            if (state_reg == S_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        a_reg     <= ina[MANT_BITS-1:0];
                        b_reg     <= inb[MANT_BITS-1:0];
                        total_reg <= {1'b0, s_tdata[100:96]} + {1'b0, s_tdata[202:198]};
                        neg_reg   <= s_tdata[101] ^ s_tdata[203];
                        count_reg <= '0;
                        sel_b_reg <= 1'b0;
                        state_reg <= S_MUL_GO;
                    end
                end
                S_MUL_GO: state_reg <= S_MUL_WAIT;
                S_MUL_WAIT: begin
                    if (mul_done) begin
                        if (over && count_reg != total_reg) begin
                            state_reg <= S_DIV_GO;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_DIV_GO: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    // Start pulse goes out in the first wait cycle.
                    if (div_done) begin
                        if (sel_b_reg) begin
                            b_reg <= div_val;
                        end else begin
                            a_reg <= div_val;
                        end
                        sel_b_reg <= !sel_b_reg;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_MUL_GO;
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        if (over) begin
                            out_reg <= {7'd0, neg_reg ? ST_SMALL : ST_LARGE, 103'd0};
                        end else begin
                            out_reg <= {7'd0, ST_OK, neg_reg,
                                        PSCALE_BITS'(total_reg - count_reg), prod96};
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
